### src/two_button_debounce_autorepeat_defines.svh
// ----------------------------------------------------------------------------
// Two-button debounce assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define TWO_BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// Same-cycle implication.
`define TBDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tbda_pkg.sv
// ----------------------------------------------------------------------------
// Two-button debounce package
// Request and result types, configuration types, codes and reset values.
// ----------------------------------------------------------------------------
package tbda_pkg;

  localparam int CFG_WIDTH  = 24;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 4;

  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [1:0] REG_FIRST_DELAY    = 2'd1;
  localparam logic [1:0] REG_INTERVAL       = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET = 24'd20000;
  localparam logic [CFG_WIDTH-1:0] FIRST_DELAY_RESET    = 24'd600000;
  localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET       = 24'd300000;

  localparam logic [1:0] PH_WAIT        = 2'd0;
  localparam logic [1:0] PH_PRESS_DEB   = 2'd1;
  localparam logic [1:0] PH_PRESSED     = 2'd2;
  localparam logic [1:0] PH_RELEASE_DEB = 2'd3;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_SEEN     = 2'd1;
  localparam logic [1:0] EV_STABLE   = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  localparam logic [7:0] PENDING_MAX = 8'd255;

  typedef struct packed {
    logic left_pressed;
    logic right_pressed;
    logic take_click;
    logic take_increment;
  } item_t;

  typedef struct packed {
    logic       click_out;
    logic       increment_out;
    logic [7:0] pending_count;
    logic [1:0] event_code;
    logic [1:0] event_button;
    logic [1:0] phase;
  } result_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] repeat_first_delay;
    logic [CFG_WIDTH-1:0] repeat_interval;
  } cfg_t;

  // Left has priority over right.
  function automatic logic [1:0] classify(input logic [1:0] bits);
    logic [1:0] btn;
    if (bits[0]) begin
      btn = BTN_LEFT;
    end else if (bits[1]) begin
      btn = BTN_RIGHT;
    end else begin
      btn = BTN_NONE;
    end
    return btn;
  endfunction

endpackage

### src/two_button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// Two-button debounce with auto-repeat
// Each request is one microsecond tick carrying two button samples and two
// consumer strobes; each request produces exactly one result.
// ----------------------------------------------------------------------------
// The state machine, timers and counters update in a single pass at the edge
// where a request is accepted, and the result is captured in the output
// register at that same edge, so it can be taken in the following cycle.
// A new request is accepted every cycle while the output register is empty
// or being drained, so the sustained rate is one request per cycle, limited
// only by the single result register when the consumer stalls. Timing
// registers are written through the APB port at byte addresses 0, 4 and 8
// and should be changed only while the block is idle.
module two_button_debounce_autorepeat #(
  parameter int TIMER_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tbda_pkg::item_t                 in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tbda_pkg::result_t               out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbda_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tbda_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tbda_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);

  tbda_pkg::cfg_t    cfg;
  tbda_pkg::result_t res;
  logic              step;
  logic              busy;

  assign in_stall = busy;
  assign step     = in_valid && !busy;

  tbda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbda_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  tbda_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### src/tbda_regs.sv
// ----------------------------------------------------------------------------
// Two-button debounce configuration registers
// APB-style register file holding the debounce and auto-repeat timings.
// ----------------------------------------------------------------------------
module tbda_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tbda_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [tbda_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [tbda_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                pready,
  output tbda_pkg::cfg_t                      cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= tbda_pkg::DEBOUNCE_TICKS_RESET;
      cfg.repeat_first_delay <= tbda_pkg::FIRST_DELAY_RESET;
      cfg.repeat_interval    <= tbda_pkg::INTERVAL_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        tbda_pkg::REG_DEBOUNCE_TICKS: begin
          cfg.debounce_ticks <= pwdata[tbda_pkg::CFG_WIDTH-1:0];
        end
        tbda_pkg::REG_FIRST_DELAY: begin
          cfg.repeat_first_delay <= pwdata[tbda_pkg::CFG_WIDTH-1:0];
        end
        tbda_pkg::REG_INTERVAL: begin
          cfg.repeat_interval <= pwdata[tbda_pkg::CFG_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tbda_pkg::REG_DEBOUNCE_TICKS: prdata = tbda_pkg::DATA_WIDTH'(cfg.debounce_ticks);
      tbda_pkg::REG_FIRST_DELAY:    prdata = tbda_pkg::DATA_WIDTH'(cfg.repeat_first_delay);
      tbda_pkg::REG_INTERVAL:       prdata = tbda_pkg::DATA_WIDTH'(cfg.repeat_interval);
      default:                      prdata = '0;
    endcase
  end

endmodule

### src/tbda_core.sv
// ----------------------------------------------------------------------------
// Two-button debounce core
// Debounce state machine, auto-repeat timing and the consumer strobes.
// ----------------------------------------------------------------------------
module tbda_core #(
  parameter int TIMER_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tbda_pkg::item_t   item,
  input  tbda_pkg::cfg_t    cfg,
  output tbda_pkg::result_t res
);

  logic [1:0]             phase;
  logic [1:0]             phase_next;
  logic [1:0]             active_button;
  logic [1:0]             active_button_next;
  logic                   repeat_armed;
  logic                   repeat_armed_next;
  logic                   has_repeated;
  logic                   has_repeated_next;
  logic [7:0]             pending;
  logic [7:0]             pending_next;
  logic                   click_flag;
  logic                   click_flag_next;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  logic [1:0]             prev_sample;
  logic [31:0]            time_now;
  logic [31:0]            time_now_next;
  logic [31:0]            deadline;
  logic [31:0]            deadline_next;

  logic [1:0]             now_bits;
  logic [1:0]             edges;
  logic [1:0]             cur;
  logic [1:0]             prev;
  logic [31:0]            ticks_ext;
  logic [TIMER_WIDTH-1:0] timer_load;
  logic                   timer_expire;
  logic [31:0]            until_deadline;
  logic                   add_inc;
  logic                   click_set;
  logic [7:0]             pending_sat;
  logic [1:0]             ev;
  logic [1:0]             ev_btn;

  assign now_bits       = {item.right_pressed, item.left_pressed};
  assign edges          = now_bits & ~prev_sample;
  assign cur            = tbda_pkg::classify(now_bits);
  assign prev           = tbda_pkg::classify(prev_sample);
  assign time_now_next  = time_now + 32'd1;
  assign ticks_ext      = 32'(cfg.debounce_ticks);
  assign timer_load     = (ticks_ext[TIMER_WIDTH-1:0] == '0) ? TIMER_WIDTH'(1)
                                                            : ticks_ext[TIMER_WIDTH-1:0];
  assign timer_expire   = (timer <= TIMER_WIDTH'(1));
  assign until_deadline = time_now_next - deadline;

  always_comb begin
    phase_next         = phase;
    active_button_next = active_button;
    repeat_armed_next  = repeat_armed;
    has_repeated_next  = has_repeated;
    timer_next         = timer;
    deadline_next      = deadline;
    add_inc            = 1'b0;
    click_set          = 1'b0;
    ev                 = tbda_pkg::EV_NONE;
    ev_btn             = tbda_pkg::BTN_NONE;

    if ((phase == tbda_pkg::PH_WAIT || phase == tbda_pkg::PH_PRESSED) && edges != 2'b00) begin
      active_button_next = edges[0] ? tbda_pkg::BTN_LEFT : tbda_pkg::BTN_RIGHT;
      phase_next         = tbda_pkg::PH_PRESS_DEB;
      timer_next         = timer_load;
      ev                 = tbda_pkg::EV_SEEN;
      ev_btn             = active_button_next;
    end else begin
      case (phase)
        tbda_pkg::PH_PRESS_DEB: begin
          if (timer_expire) begin
            timer_next = '0;
            if (prev == active_button && cur == active_button) begin
              phase_next = tbda_pkg::PH_PRESSED;
              ev         = tbda_pkg::EV_STABLE;
              ev_btn     = active_button;
              if (active_button == tbda_pkg::BTN_RIGHT) begin
                repeat_armed_next = 1'b1;
                has_repeated_next = 1'b0;
                deadline_next     = time_now_next + 32'(cfg.repeat_first_delay);
              end
            end else begin
              phase_next         = tbda_pkg::PH_WAIT;
              active_button_next = tbda_pkg::BTN_NONE;
            end
          end else begin
            timer_next = timer - TIMER_WIDTH'(1);
          end
        end
        tbda_pkg::PH_PRESSED: begin
          if (cur == tbda_pkg::BTN_NONE) begin
            phase_next = tbda_pkg::PH_RELEASE_DEB;
            timer_next = timer_load;
          end else if (repeat_armed && cur == tbda_pkg::BTN_RIGHT && !until_deadline[31]) begin
            add_inc           = 1'b1;
            has_repeated_next = 1'b1;
            deadline_next     = deadline + 32'(cfg.repeat_interval);
          end
        end
        tbda_pkg::PH_RELEASE_DEB: begin
          if (timer_expire) begin
            timer_next = '0;
            if (prev == tbda_pkg::BTN_NONE && cur == tbda_pkg::BTN_NONE) begin
              ev     = tbda_pkg::EV_RELEASED;
              ev_btn = active_button;
              if (active_button == tbda_pkg::BTN_LEFT) begin
                click_set = 1'b1;
              end else if (active_button == tbda_pkg::BTN_RIGHT && !has_repeated) begin
                add_inc = 1'b1;
              end
              active_button_next = tbda_pkg::BTN_NONE;
              repeat_armed_next  = 1'b0;
              has_repeated_next  = 1'b0;
              phase_next         = tbda_pkg::PH_WAIT;
            end else begin
              phase_next = tbda_pkg::PH_PRESSED;
            end
          end else begin
            timer_next = timer - TIMER_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pending_sat = (add_inc && pending != tbda_pkg::PENDING_MAX) ? pending + 8'd1 : pending;
    res = '0;
    click_flag_next = click_flag | click_set;
    if (item.take_click) begin
      res.click_out   = click_flag_next;
      click_flag_next = 1'b0;
    end
    pending_next = pending_sat;
    if (item.take_increment && pending_sat != 8'd0) begin
      pending_next      = pending_sat - 8'd1;
      res.increment_out = 1'b1;
    end
    res.pending_count = pending_next;
    res.event_code    = ev;
    res.event_button  = (ev == tbda_pkg::EV_NONE) ? tbda_pkg::BTN_NONE : ev_btn;
    res.phase         = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tbda_pkg::PH_WAIT;
      active_button <= tbda_pkg::BTN_NONE;
      repeat_armed  <= 1'b0;
      has_repeated  <= 1'b0;
      pending       <= '0;
      click_flag    <= 1'b0;
      timer         <= '0;
      prev_sample   <= '0;
      time_now      <= '0;
      deadline      <= '0;
    end else if (step) begin
      phase         <= phase_next;
      active_button <= active_button_next;
      repeat_armed  <= repeat_armed_next;
      has_repeated  <= has_repeated_next;
      pending       <= pending_next;
      click_flag    <= click_flag_next;
      timer         <= timer_next;
      prev_sample   <= now_bits;
      time_now      <= time_now_next;
      deadline      <= deadline_next;
    end
  end

endmodule

### src/tbda_outreg.sv
// ----------------------------------------------------------------------------
// Two-button debounce result register
// Holds one result until the consumer takes it and applies back-pressure.
// ----------------------------------------------------------------------------
module tbda_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tbda_pkg::result_t res,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output tbda_pkg::result_t out_item
);

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

### src/tbda_checker.sv
// ----------------------------------------------------------------------------
// Two-button debounce port checker
// Checks event and phase consistency, result hold under stall and a result per accepted request.
// ----------------------------------------------------------------------------
`include "two_button_debounce_autorepeat_defines.svh"

module tbda_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tbda_pkg::result_t out_item
);

  `TBDA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")
  `TBDA_ASSERT_IMP(a_seen_phase, out_valid && out_item.event_code == tbda_pkg::EV_SEEN, out_item.phase == tbda_pkg::PH_PRESS_DEB && out_item.event_button != tbda_pkg::BTN_NONE, "press seen without press debounce")
  `TBDA_ASSERT_IMP(a_stable_phase, out_valid && out_item.event_code == tbda_pkg::EV_STABLE, out_item.phase == tbda_pkg::PH_PRESSED, "stable press not in pressed phase")
  `TBDA_ASSERT_IMP(a_release_phase, out_valid && out_item.event_code == tbda_pkg::EV_RELEASED, out_item.phase == tbda_pkg::PH_WAIT, "release not followed by wait")
  `TBDA_ASSERT_NXT(a_accept_result, in_valid && !in_stall, out_valid, "accepted request gave no result")

endmodule

bind two_button_debounce_autorepeat tbda_checker u_tbda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### tb/tb_two_button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// Two-button debounce with auto-repeat testbench
// Sends one tick request per button sample set. Each request runs through a
// cycle-level predictor of the debounce, click and increment logic, and the
// block's results are compared field by field in order. A short directed
// table comes first, followed by random held-button runs and bounce noise
// under several timing settings. Both handshake sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_two_button_debounce_autorepeat;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PLAN_ROWS = 27;
  localparam int SETUP_ROWS = 3;

  typedef struct packed {
    tbda_pkg::item_t   req;
    logic              typed;
    tbda_pkg::result_t want;
  } row_t;

  localparam tbda_pkg::result_t IDLE_WAIT = {1'b0, 1'b0, 8'd0, tbda_pkg::EV_NONE,
                                             tbda_pkg::BTN_NONE, tbda_pkg::PH_WAIT};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  tbda_pkg::item_t in_item;
  logic out_valid;
  logic out_stall;
  tbda_pkg::result_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tbda_pkg::ADDR_WIDTH-1:0] paddr;
  logic [tbda_pkg::DATA_WIDTH-1:0] pwdata;
  logic [tbda_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;

  logic req_typed;
  tbda_pkg::result_t req_want;

  tbda_pkg::cfg_t timing;
  logic [1:0] st_phase;
  logic [1:0] st_button;
  logic st_armed;
  logic st_repeated;
  logic [7:0] st_pending;
  logic st_click;
  logic [tbda_pkg::CFG_WIDTH-1:0] st_timer;
  logic [1:0] st_prev_bits;
  logic [31:0] st_clock;
  logic [31:0] st_deadline;

  tbda_pkg::result_t tick_results_due[$];
  int mismatches;
  int requests_sent;
  int quiet_cycles;
  bit calm;
  bit hold_off_req;

  // Request bits are left, right, take click, take increment.
  row_t plan [0:PLAN_ROWS-1] = '{
    '{4'b0000, 1'b1, IDLE_WAIT},
    '{4'b0011, 1'b1, IDLE_WAIT},
    '{4'b0000, 1'b1, IDLE_WAIT},
    '{4'b1000, 1'b1, {1'b0, 1'b0, 8'd0, tbda_pkg::EV_SEEN, tbda_pkg::BTN_LEFT,
                      tbda_pkg::PH_PRESS_DEB}},
    '{4'b1000, 1'b1, {1'b0, 1'b0, 8'd0, tbda_pkg::EV_STABLE, tbda_pkg::BTN_LEFT,
                      tbda_pkg::PH_PRESSED}},
    '{4'b0000, 1'b1, {1'b0, 1'b0, 8'd0, tbda_pkg::EV_NONE, tbda_pkg::BTN_NONE,
                      tbda_pkg::PH_RELEASE_DEB}},
    '{4'b0000, 1'b1, {1'b0, 1'b0, 8'd0, tbda_pkg::EV_RELEASED, tbda_pkg::BTN_LEFT,
                      tbda_pkg::PH_WAIT}},
    '{4'b0010, 1'b1, {1'b1, 1'b0, 8'd0, tbda_pkg::EV_NONE, tbda_pkg::BTN_NONE,
                      tbda_pkg::PH_WAIT}},
    '{4'b0010, 1'b1, IDLE_WAIT},
    '{4'b0100, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0101, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b1100, 1'b0, '0},
    '{4'b1101, 1'b0, '0},
    '{4'b1000, 1'b0, '0},
    '{4'b1100, 1'b0, '0},
    '{4'b0011, 1'b0, '0}
  };

  two_button_debounce_autorepeat dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    timing.debounce_ticks = tbda_pkg::DEBOUNCE_TICKS_RESET;
    timing.repeat_first_delay = tbda_pkg::FIRST_DELAY_RESET;
    timing.repeat_interval = tbda_pkg::INTERVAL_RESET;
    st_phase = tbda_pkg::PH_WAIT;
    st_button = tbda_pkg::BTN_NONE;
    st_armed = 1'b0;
    st_repeated = 1'b0;
    st_pending = 8'd0;
    st_click = 1'b0;
    st_timer = '0;
    st_prev_bits = 2'b00;
    st_clock = 32'd0;
    st_deadline = 32'd0;
  end

  function automatic logic [1:0] level_owner(input logic [1:0] bits);
    if (bits[0]) begin
      return tbda_pkg::BTN_LEFT;
    end else if (bits[1]) begin
      return tbda_pkg::BTN_RIGHT;
    end
    return tbda_pkg::BTN_NONE;
  endfunction

  function automatic void load_debounce();
    st_timer = (timing.debounce_ticks == '0) ? tbda_pkg::CFG_WIDTH'(1)
                                             : timing.debounce_ticks;
  endfunction

  function automatic bit debounce_expired();
    if (st_timer <= tbda_pkg::CFG_WIDTH'(1)) begin
      st_timer = '0;
      return 1'b1;
    end
    st_timer = st_timer - tbda_pkg::CFG_WIDTH'(1);
    return 1'b0;
  endfunction

  function automatic void bump_pending();
    if (st_pending != tbda_pkg::PENDING_MAX) begin
      st_pending = st_pending + 8'd1;
    end
  endfunction

  function automatic tbda_pkg::result_t next_tick_result(input tbda_pkg::item_t it);
    logic [1:0] bits;
    logic [1:0] edges;
    logic [1:0] cur;
    logic [1:0] prv;
    logic [31:0] lag;
    tbda_pkg::result_t r;
    r = '0;
    bits = {it.right_pressed, it.left_pressed};
    cur = level_owner(bits);
    prv = level_owner(st_prev_bits);
    edges = bits & ~st_prev_bits;
    st_clock = st_clock + 32'd1;
    if ((st_phase == tbda_pkg::PH_WAIT || st_phase == tbda_pkg::PH_PRESSED) &&
        edges != 2'b00) begin
      st_button = edges[0] ? tbda_pkg::BTN_LEFT : tbda_pkg::BTN_RIGHT;
      st_phase = tbda_pkg::PH_PRESS_DEB;
      load_debounce();
      r.event_code = tbda_pkg::EV_SEEN;
      r.event_button = st_button;
    end else if (st_phase == tbda_pkg::PH_PRESS_DEB) begin
      if (debounce_expired()) begin
        if (prv == st_button && cur == st_button) begin
          st_phase = tbda_pkg::PH_PRESSED;
          r.event_code = tbda_pkg::EV_STABLE;
          r.event_button = st_button;
          if (st_button == tbda_pkg::BTN_RIGHT) begin
            st_armed = 1'b1;
            st_repeated = 1'b0;
            st_deadline = st_clock + 32'(timing.repeat_first_delay);
          end
        end else begin
          st_phase = tbda_pkg::PH_WAIT;
          st_button = tbda_pkg::BTN_NONE;
        end
      end
    end else if (st_phase == tbda_pkg::PH_PRESSED) begin
      if (cur == tbda_pkg::BTN_NONE) begin
        st_phase = tbda_pkg::PH_RELEASE_DEB;
        load_debounce();
      end else if (st_armed && cur == tbda_pkg::BTN_RIGHT) begin
        lag = st_clock - st_deadline;
        if (!lag[31]) begin
          bump_pending();
          st_repeated = 1'b1;
          st_deadline = st_deadline + 32'(timing.repeat_interval);
        end
      end
    end else if (st_phase == tbda_pkg::PH_RELEASE_DEB) begin
      if (debounce_expired()) begin
        if (prv == tbda_pkg::BTN_NONE && cur == tbda_pkg::BTN_NONE) begin
          r.event_code = tbda_pkg::EV_RELEASED;
          r.event_button = st_button;
          if (st_button == tbda_pkg::BTN_LEFT) begin
            st_click = 1'b1;
          end else if (st_button == tbda_pkg::BTN_RIGHT && !st_repeated) begin
            bump_pending();
          end
          st_button = tbda_pkg::BTN_NONE;
          st_armed = 1'b0;
          st_repeated = 1'b0;
          st_phase = tbda_pkg::PH_WAIT;
        end else begin
          st_phase = tbda_pkg::PH_PRESSED;
        end
      end
    end
    if (it.take_click) begin
      r.click_out = st_click;
      st_click = 1'b0;
    end
    if (it.take_increment && st_pending != 8'd0) begin
      st_pending = st_pending - 8'd1;
      r.increment_out = 1'b1;
    end
    st_prev_bits = bits;
    r.pending_count = st_pending;
    r.phase = st_phase;
    return r;
  endfunction

  function automatic string show(input tbda_pkg::result_t r);
    return $sformatf("click=%0d inc=%0d pending=%0d event=%0d button=%0d phase=%0d",
                     r.click_out, r.increment_out, r.pending_count, r.event_code,
                     r.event_button, r.phase);
  endfunction

  // Prediction is pushed before the check so that a same-cycle result
  // would still find its expectation.
  always @(posedge clk) begin : track_ticks
    tbda_pkg::result_t predicted;
    tbda_pkg::result_t want;
    if (!rst && in_valid && !in_stall) begin
      predicted = next_tick_result(in_item);
      tick_results_due.push_back(req_typed ? req_want : predicted);
    end
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: %s", show(out_item));
        end
        mismatches++;
      end else begin
        want = tick_results_due.pop_front();
        if (out_item.click_out !== want.click_out ||
            out_item.increment_out !== want.increment_out ||
            out_item.pending_count !== want.pending_count ||
            out_item.event_code !== want.event_code ||
            out_item.event_button !== want.event_button ||
            out_item.phase !== want.phase) begin
          if (mismatches < 10) begin
            $display("result mismatch: expected %s", show(want));
            $display("                 actual   %s", show(out_item));
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  task automatic send_request(input tbda_pkg::item_t it, input logic typed,
                              input tbda_pkg::result_t want);
    bit taken;
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    req_typed <= typed;
    req_want <= want;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  task automatic hold_buttons(input logic [1:0] bits, input int len, input int take_pct);
    tbda_pkg::item_t it;
    repeat (len) begin
      it.left_pressed = bits[0];
      it.right_pressed = bits[1];
      it.take_click = $urandom_range(99) < take_pct;
      it.take_increment = $urandom_range(99) < take_pct;
      send_request(it, 1'b0, '0);
    end
  endtask

  // Mostly clean held levels of random length, with short bursts of bounce.
  task automatic run_random(input int n, input int maxlen, input int take_pct);
    int stop;
    int pick;
    logic [1:0] bits;
    stop = requests_sent + n;
    while (requests_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if (pick < 32) begin
          bits = 2'b10;
        end else if (pick < 52) begin
          bits = 2'b01;
        end else if (pick < 60) begin
          bits = 2'b11;
        end else begin
          bits = 2'b00;
        end
        hold_buttons(bits, $urandom_range(1, maxlen), take_pct);
      end else begin
        repeat ($urandom_range(1, 4)) hold_buttons(2'($urandom_range(3)), 1, take_pct);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tick_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [tbda_pkg::CFG_WIDTH-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(tbda_pkg::DATA_WIDTH - tbda_pkg::CFG_WIDTH){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tbda_pkg::REG_DEBOUNCE_TICKS: begin
        timing.debounce_ticks = value;
      end
      tbda_pkg::REG_FIRST_DELAY: begin
        timing.repeat_first_delay = value;
      end
      default: begin
        timing.repeat_interval = value;
      end
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [tbda_pkg::DATA_WIDTH-1:0] want;
    case (idx)
      tbda_pkg::REG_DEBOUNCE_TICKS: begin
        want = tbda_pkg::DATA_WIDTH'(timing.debounce_ticks);
      end
      tbda_pkg::REG_FIRST_DELAY: begin
        want = tbda_pkg::DATA_WIDTH'(timing.repeat_first_delay);
      end
      default: begin
        want = tbda_pkg::DATA_WIDTH'(timing.repeat_interval);
      end
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      if (mismatches < 10) begin
        $display("register %0d readback: expected %0d, actual %0d", idx, want, prdata);
      end
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_timing(input logic [tbda_pkg::CFG_WIDTH-1:0] deb,
                              input logic [tbda_pkg::CFG_WIDTH-1:0] first,
                              input logic [tbda_pkg::CFG_WIDTH-1:0] interval);
    drain_results();
    write_reg(tbda_pkg::REG_DEBOUNCE_TICKS, deb);
    write_reg(tbda_pkg::REG_FIRST_DELAY, first);
    write_reg(tbda_pkg::REG_INTERVAL, interval);
    check_reg(tbda_pkg::REG_DEBOUNCE_TICKS);
    check_reg(tbda_pkg::REG_FIRST_DELAY);
    check_reg(tbda_pkg::REG_INTERVAL);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    req_typed = 1'b0;
    req_want = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    requests_sent = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    check_reg(tbda_pkg::REG_DEBOUNCE_TICKS);
    check_reg(tbda_pkg::REG_FIRST_DELAY);
    check_reg(tbda_pkg::REG_INTERVAL);

    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (k == SETUP_ROWS) begin
        apply_timing(24'd1, 24'd1, 24'd1);
      end
      send_request(plan[k].req, plan[k].typed, plan[k].want);
    end

    // Long right hold with nothing taken drives the count into saturation.
    apply_timing(24'd1, 24'd1, 24'd1);
    calm = 1'b1;
    hold_buttons(2'b00, 3, 0);
    hold_buttons(2'b10, 300, 0);
    run_random(200, 30, 30);
    calm = 1'b0;

    // A zero debounce setting behaves as a single tick.
    apply_timing(24'd0, 24'd5, 24'd3);
    run_random(150, 25, 30);
    hold_off_req = 1'b1;
    run_random(200, 25, 30);

    apply_timing(24'd4, 24'd30, 24'd9);
    run_random(350, 60, 40);

    apply_timing(24'd2, 24'hFFFFFF, 24'hFFFFFF);
    run_random(150, 20, 30);

    apply_timing(24'hFFFFFF, 24'd1, 24'hFFFFFF);
    hold_buttons(2'b01, 3, 50);
    hold_buttons(2'b00, 5, 50);
    hold_buttons(2'b10, 3, 50);
    hold_buttons(2'b11, 4, 50);

    drain_results();
    repeat (4) @(posedge clk);
    if (tick_results_due.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
